@@ design/tqs_pkg.sv @@
`default_nettype none
package tqs_pkg;

  localparam int unsigned SampleWidth = 10;
  localparam int unsigned ShiftWidth  = 3;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 10;

  typedef logic [SampleWidth-1:0] sample_t;
  typedef logic [ShiftWidth-1:0]  shift_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_WIN_MIN_X   = 3'd0,
    CFG_WIN_MAX_X   = 3'd1,
    CFG_WIN_MIN_Y   = 3'd2,
    CFG_WIN_MAX_Y   = 3'd3,
    CFG_REL_LEVEL   = 3'd4,
    CFG_SMOOTH_SHFT = 3'd5
  } cfg_idx_e;

  localparam sample_t WinMinReset   = 10'd26;
  localparam sample_t WinMaxReset   = 10'd998;
  localparam sample_t RelLevelReset = 10'h3fc;
  localparam shift_t  ShiftReset    = 3'd2;

  typedef struct packed {
    sample_t win_min_x;
    sample_t win_max_x;
    sample_t win_min_y;
    sample_t win_max_y;
    sample_t rel_level;
    shift_t  smooth_shift;
  } tqs_cfg_t;

  typedef struct packed {
    sample_t x;
    sample_t y;
    sample_t z;
  } tqs_sample_t;

  typedef struct packed {
    logic    touch_down;
    logic    position_valid;
    sample_t x_position;
    sample_t y_position;
  } tqs_result_t;

  function automatic sample_t smooth_step(sample_t f, sample_t s, shift_t sh);
    logic [SampleWidth:0] sum;
    sum = {1'b0, f} + {1'b0, s >> sh} - {1'b0, f >> sh};
    return sum[SampleWidth-1:0];
  endfunction

endpackage
`default_nettype wire

@@ design/tqs_cfg_regs.sv @@
`default_nettype none
module tqs_cfg_regs import tqs_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_wdata_i,
  output tqs_cfg_t                     cfg_o
);

  tqs_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_min_x    <= WinMinReset;
      cfg_q.win_max_x    <= WinMaxReset;
      cfg_q.win_min_y    <= WinMinReset;
      cfg_q.win_max_y    <= WinMaxReset;
      cfg_q.rel_level    <= RelLevelReset;
      cfg_q.smooth_shift <= ShiftReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIN_MIN_X:   cfg_q.win_min_x    <= cfg_wdata_i[SampleWidth-1:0];
        CFG_WIN_MAX_X:   cfg_q.win_max_x    <= cfg_wdata_i[SampleWidth-1:0];
        CFG_WIN_MIN_Y:   cfg_q.win_min_y    <= cfg_wdata_i[SampleWidth-1:0];
        CFG_WIN_MAX_Y:   cfg_q.win_max_y    <= cfg_wdata_i[SampleWidth-1:0];
        CFG_REL_LEVEL:   cfg_q.rel_level    <= cfg_wdata_i[SampleWidth-1:0];
        CFG_SMOOTH_SHFT: cfg_q.smooth_shift <= cfg_wdata_i[ShiftWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ design/tqs_track.sv @@
`default_nettype none
module tqs_track import tqs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire tqs_cfg_t    cfg_i,
  input  wire logic        advance_i,
  input  wire tqs_sample_t sample_i,
  output tqs_result_t      result_o
);

  logic    was_touching_q, was_touching_d;
  logic    have_pos_q, have_pos_d;
  sample_t filt_x_q, filt_x_d;
  sample_t filt_y_q, filt_y_d;
  logic    in_window;
  logic    touching;

  always_comb begin
    in_window = (sample_i.x >= cfg_i.win_min_x) && (sample_i.x <= cfg_i.win_max_x) &&
                (sample_i.y >= cfg_i.win_min_y) && (sample_i.y <= cfg_i.win_max_y);
    touching  = in_window && (sample_i.z < cfg_i.rel_level);

    was_touching_d = was_touching_q;
    have_pos_d     = have_pos_q;
    filt_x_d       = filt_x_q;
    filt_y_d       = filt_y_q;
    result_o       = '0;

    if (touching) begin
      if (was_touching_q) begin
        if (!have_pos_q) begin
          filt_x_d   = sample_i.x;
          filt_y_d   = sample_i.y;
          have_pos_d = 1'b1;
        end else begin
          filt_x_d = smooth_step(filt_x_q, sample_i.x, cfg_i.smooth_shift);
          filt_y_d = smooth_step(filt_y_q, sample_i.y, cfg_i.smooth_shift);
        end
        result_o.touch_down     = 1'b1;
        result_o.position_valid = 1'b1;
        result_o.x_position     = filt_x_d;
        result_o.y_position     = filt_y_d;
      end
      was_touching_d = 1'b1;
    end else begin
      was_touching_d = 1'b0;
      have_pos_d     = 1'b0;
      filt_x_d       = '0;
      filt_y_d       = '0;
    end
  end

  // advance tracking state only when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_touching_q <= 1'b0;
      have_pos_q     <= 1'b0;
      filt_x_q       <= '0;
      filt_y_q       <= '0;
    end else if (advance_i) begin
      was_touching_q <= was_touching_d;
      have_pos_q     <= have_pos_d;
      filt_x_q       <= filt_x_d;
      filt_y_q       <= filt_y_d;
    end
  end

endmodule
`default_nettype wire

@@ design/touch_qualify_and_smooth_core.sv @@
`default_nettype none
// Touch sample qualifier and position smoother.
// Input channel: in_valid_i / in_stall_o carries one polled sample (sample_ok_i,
// x_sample_i, y_sample_i, z_sample_i). A transfer with sample_ok_i low is dropped
// and produces no result.
// Output channel: out_valid_o / out_stall_i carries one result per good sample
// (touch_down_o, position_valid_o, x_position_o, y_position_o).
// out_valid_o rises and the result can transfer after the sample has passed the
// input register, then window/pressure compare and shift-add smoothing into the
// result register.
// Throughput is one sample per cycle while the receiver does not stall, set by
// the combinational tracking update between the two registers.
// When the receiver stalls, the result register holds; the input register can
// hold one more sample, and in_stall_o is high while it is full until taken.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i;
// unknown indexes are ignored. Write only while the block is empty.
// Reset clears both pipeline stages and the tracking state and loads the
// register defaults (window 26..998, release level 1020, shift 2).
module touch_qualify_and_smooth_core import tqs_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    sample_ok_i,
  input  wire logic [SampleWidth-1:0]  x_sample_i,
  input  wire logic [SampleWidth-1:0]  y_sample_i,
  input  wire logic [SampleWidth-1:0]  z_sample_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic                         touch_down_o,
  output logic                         position_valid_o,
  output logic [SampleWidth-1:0]       x_position_o,
  output logic [SampleWidth-1:0]       y_position_o
);

  tqs_cfg_t    cfg;
  tqs_sample_t smp_q;
  logic        smp_vld_q;
  tqs_result_t res_d, res_q;
  logic        res_vld_q;
  logic        res_free;
  logic        advance;
  logic        in_take;

  tqs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign res_free   = !res_vld_q || !out_stall_i;
  assign advance    = smp_vld_q && res_free;
  assign in_stall_o = smp_vld_q && !res_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
    end else if (in_take) begin
      smp_vld_q <= sample_ok_i;
    end else if (advance) begin
      smp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && sample_ok_i) begin
      smp_q.x <= x_sample_i;
      smp_q.y <= y_sample_i;
      smp_q.z <= z_sample_i;
    end
  end

  tqs_track u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .advance_i (advance),
    .sample_i  (smp_q),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= smp_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = res_vld_q;
  assign touch_down_o     = res_q.touch_down;
  assign position_valid_o = res_q.position_valid;
  assign x_position_o     = res_q.x_position;
  assign y_position_o     = res_q.y_position;

endmodule
`default_nettype wire
